>>> rtl/lidar_point_to_world_xyz_macros.svh
// Assertion macros for the lidar point converter.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef LIDAR_POINT_TO_WORLD_XYZ_MACROS_SVH
`define LIDAR_POINT_TO_WORLD_XYZ_MACROS_SVH

// Check that a condition implies another in the same cycle
`define LP2W_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define LP2W_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lp2w_pkg.sv
// Shared types, constants and helper functions of the lidar point converter.
// No dependencies.
`timescale 1ns / 1ps

package lp2w_pkg;

  // Angle units: 1/64 degree, interpolated angles carry 8 more fraction bits
  localparam int TURN_U        = 23040;
  localparam int TURN_F        = TURN_U * 256;
  localparam int HALF_F        = TURN_F / 2;
  localparam int QUARTER_F     = TURN_F / 4;
  localparam int ANG_W         = 23;
  localparam int Z_W           = 24;
  localparam int XY_W          = 19;
  localparam int CORDIC_STAGES = 18;
  localparam int CORDIC_X0     = 39797;
  localparam int ARM_RESET     = 400;
  localparam int ARM_W         = 12;
  localparam int MID_DEPTH     = 4;

  // Transaction handed from the front end to the back end
  typedef struct packed {
    logic [ANG_W-1:0] angle;
    logic [ANG_W-1:0] yaw;
    logic [15:0]      range;
    logic [7:0]       quality;
  } work_t;

  // Side data carried along the CORDIC stages
  typedef struct packed {
    logic        neg_a;
    logic        neg_y;
    logic [15:0] range;
    logic [7:0]  quality;
  } side_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic ready;
    logic first_valid;
    logic last_valid;
  } front_stat_t;

  // Arctangent table in units of 1/16384 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] cordic_atan(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:       r = 24'sd737280;
      1:       r = 24'sd435242;
      2:       r = 24'sd229970;
      3:       r = 24'sd116736;
      4:       r = 24'sd58595;
      5:       r = 24'sd29326;
      6:       r = 24'sd14667;
      7:       r = 24'sd7334;
      8:       r = 24'sd3667;
      9:       r = 24'sd1833;
      10:      r = 24'sd917;
      11:      r = 24'sd458;
      12:      r = 24'sd229;
      13:      r = 24'sd115;
      14:      r = 24'sd57;
      15:      r = 24'sd29;
      16:      r = 24'sd14;
      17:      r = 24'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate a signed whole-mm value to 16 bits
  function automatic logic [15:0] sat16(input logic signed [40:0] v);
    logic [15:0] r;
    if (v > 41'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -41'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/lidar_point_to_world_xyz.sv
// Lidar range sample to world point converter, top level.
// Ties together lp2w_front, lp2w_fifo and lp2w_back; uses lp2w_pkg and the macros header.
//
// Usage:
//   Input queue: drive a sample on the field ports with push high; it is taken
//   at a clock edge where full is low. Samples with zero range, an index past
//   the packet, or scanning low are dropped and give no point.
//   Output queue: while empty is low the oldest point is on the result ports;
//   pulse pop to take it.
//   Configuration: cfg_we_i writes the arm offset from cfg_wdata_i; write only
//   while no sample is in flight.
// Rate and pipeline:
//   A sample is taken every cycle while full is low. A taken sample passes through
//   30 registers in order: 5 front stages, one queue slot, fold, 18 CORDIC
//   stages, negate, three multiply and add stages, and the output register.
// Reset and stalls:
//   Reset empties all stages and the queue and sets the arm offset to 400 mm.
//   When pop is held low with a point waiting, the back end holds as a whole; the 4-entry
//   queue then fills and full rises once the front end has its last stage occupied.
`timescale 1ns / 1ps
`include "lidar_point_to_world_xyz_macros.svh"

module lidar_point_to_world_xyz #(
  parameter int POINTS_PER_PACKET = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [15:0]                 start_angle_raw_i,
  input  logic [15:0]                 end_angle_raw_i,
  input  logic [3:0]                  sample_index_i,
  input  logic [15:0]                 range_mm_i,
  input  logic [7:0]                  sample_quality_i,
  input  logic signed [15:0]          yaw_angle_i,
  input  logic                        scanning_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [15:0]          world_x_o,
  output logic signed [15:0]          world_y_o,
  output logic signed [15:0]          world_z_o,
  output logic [7:0]                  point_quality_o,
  input  logic                        cfg_we_i,
  input  logic [lp2w_pkg::ARM_W-1:0]  cfg_wdata_i
);

  localparam int WW = $bits(lp2w_pkg::work_t);

  logic [lp2w_pkg::ARM_W-1:0] arm_q;
  lp2w_pkg::fifo_stat_t  fifo_stat;
  lp2w_pkg::front_stat_t front_stat;
  lp2w_pkg::work_t       front_item;
  logic [WW-1:0]         fifo_rdata;
  logic                  fifo_push, fifo_pop, out_valid;

  // Hold the arm offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q <= lp2w_pkg::ARM_W'(lp2w_pkg::ARM_RESET);
    end else if (cfg_we_i) begin
      arm_q <= cfg_wdata_i;
    end
  end

  lp2w_front #(
    .POINTS_PER_PACKET (POINTS_PER_PACKET)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (push & ~full),
    .start_angle_raw_i (start_angle_raw_i),
    .end_angle_raw_i   (end_angle_raw_i),
    .sample_index_i    (sample_index_i),
    .range_mm_i        (range_mm_i),
    .sample_quality_i  (sample_quality_i),
    .yaw_angle_i       (yaw_angle_i),
    .scanning_i        (scanning_i),
    .fifo_stat_i       (fifo_stat),
    .out_valid_o       (fifo_push),
    .out_item_o        (front_item),
    .stat_o            (front_stat)
  );

  lp2w_fifo #(
    .WIDTH (WW),
    .DEPTH (lp2w_pkg::MID_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (front_item),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .stat_o  (fifo_stat)
  );

  lp2w_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (lp2w_pkg::work_t'(fifo_rdata)),
    .fifo_stat_i     (fifo_stat),
    .arm_i           (arm_q),
    .pop_i           (pop),
    .fifo_pop_o      (fifo_pop),
    .out_valid_o     (out_valid),
    .world_x_o       (world_x_o),
    .world_y_o       (world_y_o),
    .world_z_o       (world_z_o),
    .point_quality_o (point_quality_o)
  );

  assign full  = ~front_stat.ready;
  assign empty = ~out_valid;

  // A sample taken while not scanning never enters the front pipeline
  `LP2W_ASSERT_NEXT(a_drop_idle, push && !full && !scanning_i, !front_stat.first_valid, "dropped sample entered pipeline")
  // Backpressure only comes from a full queue behind an occupied last stage
  `LP2W_ASSERT_SAME(a_full_cause, full, front_stat.last_valid && fifo_stat.full, "full without cause")
  // The queue is never written while full
  `LP2W_ASSERT_SAME(a_no_overflow, fifo_push, !fifo_stat.full, "queue overflow")

endmodule

>>> rtl/lp2w_front.sv
// Front end: accepts samples, drops those that give no point, and
// computes the interpolated sample angle and the reduced yaw. Uses lp2w_pkg.
`timescale 1ns / 1ps

module lp2w_front #(
  parameter int POINTS_PER_PACKET = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [15:0]            start_angle_raw_i,
  input  logic [15:0]            end_angle_raw_i,
  input  logic [3:0]             sample_index_i,
  input  logic [15:0]            range_mm_i,
  input  logic [7:0]             sample_quality_i,
  input  logic signed [15:0]     yaw_angle_i,
  input  logic                   scanning_i,
  input  lp2w_pkg::fifo_stat_t   fifo_stat_i,
  output logic                   out_valid_o,
  output lp2w_pkg::work_t        out_item_o,
  output lp2w_pkg::front_stat_t  stat_o
);

  localparam int DIV = POINTS_PER_PACKET - 1;
  localparam int RK  = lp2w_pkg::ANG_W + $clog2(DIV);
  localparam logic [63:0] RECIP = ((64'd1 << RK) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic signed [16:0] TurnS  = 17'(lp2w_pkg::TURN_U);
  localparam logic signed [16:0] Turn2S = 17'(2 * lp2w_pkg::TURN_U);
  localparam logic [14:0] TurnU15 = 15'(lp2w_pkg::TURN_U);
  localparam logic [27:0] TurnF28 = 28'(lp2w_pkg::TURN_F);

  logic [4:0] vld_q;
  logic       en;
  logic       keep;

  // Stage 1: reduced start, end and yaw
  logic [14:0] s1_start_q, s1_end_q, s1_start_d, s1_end_d, s1_yaw_d, s1_yaw_q;
  logic [3:0]  s1_idx_q;
  logic [15:0] s1_range_q;
  logic [7:0]  s1_qual_q;
  logic signed [16:0] yaw_ext;

  // Stage 2: span
  logic [14:0] s2_start_q, s2_span_q, s2_yaw_q;
  logic [14:0] s2_span_d;
  logic signed [15:0] span_diff;
  logic [3:0]  s2_idx_q;
  logic [15:0] s2_range_q;
  logic [7:0]  s2_qual_q;

  // Stage 3: step by reciprocal multiply
  logic [14:0] s3_start_q, s3_yaw_q;
  logic [22:0] s3_step_q;
  logic [55:0] recip_prod;
  logic [3:0]  s3_idx_q;
  logic [15:0] s3_range_q;
  logic [7:0]  s3_qual_q;

  // Stage 4: index times step
  logic [14:0] s4_start_q, s4_yaw_q;
  logic [26:0] s4_off_q;
  logic [15:0] s4_range_q;
  logic [7:0]  s4_qual_q;

  // Stage 5: wrapped angle
  lp2w_pkg::work_t s5_item_q;
  logic [27:0]     ang_sum;

  assign en = ~(vld_q[4] & fifo_stat_i.full);
  assign keep = in_valid_i & scanning_i & (range_mm_i != 16'd0) &
                ({2'b00, sample_index_i} < 6'(POINTS_PER_PACKET));

  // Advance the valid chain; drop samples that give no point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], keep};
    end
  end

  // Reduce angles modulo one turn
  always_comb begin
    s1_start_d = (start_angle_raw_i[14:0] >= TurnU15) ?
                 start_angle_raw_i[14:0] - TurnU15 : start_angle_raw_i[14:0];
    s1_end_d   = (end_angle_raw_i[14:0] >= TurnU15) ?
                 end_angle_raw_i[14:0] - TurnU15 : end_angle_raw_i[14:0];
    yaw_ext = {yaw_angle_i[15], yaw_angle_i};
    if (yaw_ext >= TurnS) begin
      s1_yaw_d = 15'(yaw_ext - TurnS);
    end else if (yaw_ext < -TurnS) begin
      s1_yaw_d = 15'(yaw_ext + Turn2S);
    end else if (yaw_ext < 17'sd0) begin
      s1_yaw_d = 15'(yaw_ext + TurnS);
    end else begin
      s1_yaw_d = 15'(yaw_ext);
    end
  end

  // Wrap the packet span
  always_comb begin
    span_diff = $signed({1'b0, s1_end_q}) - $signed({1'b0, s1_start_q});
    s2_span_d = (span_diff < 16'sd0) ? 15'(span_diff + 16'(lp2w_pkg::TURN_U))
                                     : 15'(span_diff);
  end

  assign recip_prod = 56'({s2_span_q, 8'h00}) * 56'(RECIP[24:0]);
  assign ang_sum = {5'd0, s4_start_q, 8'h00} + {1'b0, s4_off_q};

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_start_q <= s1_start_d;
      s1_end_q   <= s1_end_d;
      s1_yaw_q   <= s1_yaw_d;
      s1_idx_q   <= sample_index_i;
      s1_range_q <= range_mm_i;
      s1_qual_q  <= sample_quality_i;

      s2_start_q <= s1_start_q;
      s2_span_q  <= s2_span_d;
      s2_yaw_q   <= s1_yaw_q;
      s2_idx_q   <= s1_idx_q;
      s2_range_q <= s1_range_q;
      s2_qual_q  <= s1_qual_q;

      s3_start_q <= s2_start_q;
      s3_step_q  <= 23'(recip_prod >> RK);
      s3_yaw_q   <= s2_yaw_q;
      s3_idx_q   <= s2_idx_q;
      s3_range_q <= s2_range_q;
      s3_qual_q  <= s2_qual_q;

      s4_start_q <= s3_start_q;
      s4_off_q   <= 27'(s3_idx_q) * 27'(s3_step_q);
      s4_yaw_q   <= s3_yaw_q;
      s4_range_q <= s3_range_q;
      s4_qual_q  <= s3_qual_q;

      s5_item_q.angle   <= (ang_sum >= TurnF28) ? 23'(ang_sum - TurnF28) : 23'(ang_sum);
      s5_item_q.yaw     <= {s4_yaw_q, 8'h00};
      s5_item_q.range   <= s4_range_q;
      s5_item_q.quality <= s4_qual_q;
    end
  end

  assign out_valid_o        = vld_q[4] & ~fifo_stat_i.full;
  assign out_item_o         = s5_item_q;
  assign stat_o.ready       = en;
  assign stat_o.first_valid = vld_q[0];
  assign stat_o.last_valid  = vld_q[4];

endmodule

>>> rtl/lp2w_fifo.sv
// Small register queue between the front and back ends.
// Uses lp2w_pkg for the status type.
`timescale 1ns / 1ps

module lp2w_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     rdata_o,
  output lp2w_pkg::fifo_stat_t stat_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (PW+1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> rtl/lp2w_cordic.sv
// Pipelined rotation-mode CORDIC, one register stage per iteration, Q16 sine and cosine.
// Uses lp2w_pkg for the arctangent table and widths.
`timescale 1ns / 1ps

module lp2w_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [lp2w_pkg::Z_W-1:0]   z_i,
  output logic signed [lp2w_pkg::XY_W-1:0]  cos_o,
  output logic signed [lp2w_pkg::XY_W-1:0]  sin_o
);

  localparam int N = lp2w_pkg::CORDIC_STAGES;

  logic signed [lp2w_pkg::XY_W-1:0] x_q [N];
  logic signed [lp2w_pkg::XY_W-1:0] y_q [N];
  logic signed [lp2w_pkg::Z_W-1:0]  z_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [lp2w_pkg::XY_W-1:0] x_in, y_in;
    logic signed [lp2w_pkg::Z_W-1:0]  z_in;
    if (i == 0) begin : g_first
      assign x_in = lp2w_pkg::XY_W'(lp2w_pkg::CORDIC_X0);
      assign y_in = '0;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[lp2w_pkg::Z_W-1]) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - lp2w_pkg::cordic_atan(i);
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + lp2w_pkg::cordic_atan(i);
        end
      end
    end
  end

  assign cos_o = x_q[N-1];
  assign sin_o = y_q[N-1];

endmodule

>>> rtl/lp2w_back.sv
// Back end: folds angles, runs two CORDICs, scales and rotates the point,
// then truncates and saturates into the output register. Uses lp2w_pkg, lp2w_cordic.
`timescale 1ns / 1ps

module lp2w_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lp2w_pkg::work_t                 item_i,
  input  lp2w_pkg::fifo_stat_t            fifo_stat_i,
  input  logic [lp2w_pkg::ARM_W-1:0]      arm_i,
  input  logic                            pop_i,
  output logic                            fifo_pop_o,
  output logic                            out_valid_o,
  output logic signed [15:0]              world_x_o,
  output logic signed [15:0]              world_y_o,
  output logic signed [15:0]              world_z_o,
  output logic [7:0]                      point_quality_o
);

  localparam int NC   = lp2w_pkg::CORDIC_STAGES;
  localparam int LAST = NC + 5;
  localparam int XW   = lp2w_pkg::XY_W;
  localparam logic signed [23:0] TurnS    = 24'(lp2w_pkg::TURN_F);
  localparam logic signed [23:0] HalfS    = 24'(lp2w_pkg::HALF_F);
  localparam logic signed [23:0] QuarterS = 24'(lp2w_pkg::QUARTER_F);

  logic [LAST:0] vld_q;
  logic          en;

  logic signed [23:0] za_d, zy_d, za_q, zy_q;
  logic               neg_a_d, neg_y_d;
  lp2w_pkg::side_t    side_q [NC+1];

  logic signed [XW-1:0] ca, sa, cy, sy;
  logic signed [XW-1:0] n_ca_q, n_sa_q, n_cy_q, n_sy_q;
  logic [15:0]          n_range_q;
  logic [7:0]           n_qual_q;

  logic signed [35:0]   m1_yl_q, m1_zl_q;
  logic signed [31:0]   m1_acy_q, m1_asy_q;
  logic signed [XW-1:0] m1_cy_q, m1_sy_q;
  logic [7:0]           m1_qual_q;

  logic signed [54:0]   m2_p1_q, m2_p2_q;
  logic signed [31:0]   m2_acy_q, m2_asy_q;
  logic signed [35:0]   m2_zl_q;
  logic [7:0]           m2_qual_q;

  logic signed [56:0]   m3_wx_q, m3_wy_q;
  logic signed [35:0]   m3_zl_q;
  logic [7:0]           m3_qual_q;

  logic signed [24:0]   wx_t, wy_t;
  logic signed [19:0]   zl_t;
  logic [15:0]          wx_q, wy_q, wz_q;
  logic [7:0]           qual_q;

  // Fold one angle into [-90, 90] degrees
  function automatic logic [24:0] fold(input logic [lp2w_pkg::ANG_W-1:0] a);
    logic signed [23:0] s;
    logic               ng;
    s  = {1'b0, a};
    ng = 1'b0;
    if (s >= HalfS) begin
      s = s - TurnS;
    end
    if (s > QuarterS) begin
      s  = s - HalfS;
      ng = 1'b1;
    end else if (s < -QuarterS) begin
      s  = s + HalfS;
      ng = 1'b1;
    end
    return {ng, s};
  endfunction

  assign en         = ~vld_q[LAST] | pop_i;
  assign fifo_pop_o = en & ~fifo_stat_i.empty;
  assign {neg_a_d, za_d} = fold(item_i.angle);
  assign {neg_y_d, zy_d} = fold(item_i.yaw);

  // Advance the valid chain while the output register can move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], ~fifo_stat_i.empty};
    end
  end

  lp2w_cordic u_cordic_ang (
    .clk_i (clk_i),
    .en_i  (en),
    .z_i   (za_q),
    .cos_o (ca),
    .sin_o (sa)
  );

  lp2w_cordic u_cordic_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .z_i   (zy_q),
    .cos_o (cy),
    .sin_o (sy)
  );

  // Carry side data next to the CORDIC stages
  for (genvar i = 0; i < NC; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // Truncate toward zero to whole mm
  assign wx_t = 25'((m3_wx_q + (m3_wx_q[56] ? 57'sd4294967295 : 57'sd0)) >>> 32);
  assign wy_t = 25'((m3_wy_q + (m3_wy_q[56] ? 57'sd4294967295 : 57'sd0)) >>> 32);
  assign zl_t = 20'((m3_zl_q + (m3_zl_q[35] ? 36'sd65535 : 36'sd0)) >>> 16);

  // Fold, negate, scale, rotate and saturate
  always_ff @(posedge clk_i) begin
    if (en) begin
      za_q              <= za_d;
      zy_q              <= zy_d;
      side_q[0].neg_a   <= neg_a_d;
      side_q[0].neg_y   <= neg_y_d;
      side_q[0].range   <= item_i.range;
      side_q[0].quality <= item_i.quality;

      n_ca_q    <= side_q[NC].neg_a ? -ca : ca;
      n_sa_q    <= side_q[NC].neg_a ? -sa : sa;
      n_cy_q    <= side_q[NC].neg_y ? -cy : cy;
      n_sy_q    <= side_q[NC].neg_y ? -sy : sy;
      n_range_q <= side_q[NC].range;
      n_qual_q  <= side_q[NC].quality;

      m1_yl_q   <= 36'($signed({1'b0, n_range_q}) * n_ca_q);
      m1_zl_q   <= 36'($signed({1'b0, n_range_q}) * n_sa_q);
      m1_acy_q  <= 32'($signed({1'b0, arm_i}) * n_cy_q);
      m1_asy_q  <= 32'($signed({1'b0, arm_i}) * n_sy_q);
      m1_cy_q   <= n_cy_q;
      m1_sy_q   <= n_sy_q;
      m1_qual_q <= n_qual_q;

      m2_p1_q   <= 55'(m1_yl_q * m1_sy_q);
      m2_p2_q   <= 55'(m1_yl_q * m1_cy_q);
      m2_acy_q  <= m1_acy_q;
      m2_asy_q  <= m1_asy_q;
      m2_zl_q   <= m1_zl_q;
      m2_qual_q <= m1_qual_q;

      m3_wx_q   <= (57'(m2_acy_q) <<< 16) - 57'(m2_p1_q);
      m3_wy_q   <= (57'(m2_asy_q) <<< 16) + 57'(m2_p2_q);
      m3_zl_q   <= m2_zl_q;
      m3_qual_q <= m2_qual_q;

      wx_q   <= lp2w_pkg::sat16(41'(wx_t));
      wy_q   <= lp2w_pkg::sat16(41'(wy_t));
      wz_q   <= lp2w_pkg::sat16(41'(zl_t));
      qual_q <= m3_qual_q;
    end
  end

  assign out_valid_o     = vld_q[LAST];
  assign world_x_o       = $signed(wx_q);
  assign world_y_o       = $signed(wy_q);
  assign world_z_o       = $signed(wz_q);
  assign point_quality_o = qual_q;

endmodule
